FILE: hw/rtl/mdaa_pkg.sv
// ----------------------------------------------------------------------------
// mdaa_pkg: shared types and constants for the multi-dimensional array
// address unit.
// ----------------------------------------------------------------------------
package mdaa_pkg;

    // Descriptor table geometry
    localparam int MAX_ARRAYS = 16;
    localparam int MAX_DIMS   = 10;
    localparam int NUM_SLOTS  = MAX_ARRAYS * MAX_DIMS;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);

    // Fixed field widths
    localparam int FUNC_W  = 2;
    localparam int ID_W    = 4;
    localparam int DIM_W   = 4;
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 16;
    localparam int IDX_W   = 32;
    localparam int EXT_W   = IDX_W + 1;
    localparam int OUT_W   = 64;
    localparam int HALF_W  = OUT_W / 2;

    // Request function codes
    typedef enum logic [FUNC_W-1:0] {
        F_HEADER = 2'd0,
        F_BOUNDS = 2'd1,
        F_INDEX  = 2'd2
    } t_func;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_LL,
        S_MUL_HL,
        S_MUL_LH,
        S_ADD,
        S_SCL_L,
        S_SCL_H,
        S_OUT
    } t_state;

endpackage

FILE: hw/rtl/multidim_array_address_unit.sv
// ----------------------------------------------------------------------------
// multidim_array_address_unit: row-major address generator
// Keeps array descriptors and folds index components into a byte address
// with one shared 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Sequencing: a header/bounds write is stored at accept; a non-final index component
// passes through accept plus three partial products and one add on the shared multiplier;
// a final component then takes two more partial products for the element size and
// the base add into the output register.
// Requests: a new request is taken only while idle; a stalled result holds the sequencer.
// Reset: control state and output valid clear; descriptor tables do not clear.
module multidim_array_address_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [mdaa_pkg::FUNC_W-1:0]          i_func,
    input  logic [mdaa_pkg::ID_W-1:0]            i_array_id,
    input  logic [mdaa_pkg::DIM_W-1:0]           i_dim_pos,
    input  logic [mdaa_pkg::ADDR_W-1:0]          i_base_address,
    input  logic [mdaa_pkg::SIZE_W-1:0]          i_element_bytes,
    input  logic [mdaa_pkg::DIM_W-1:0]           i_dim_count,
    input  logic signed [mdaa_pkg::IDX_W-1:0]    i_lower_bound,
    input  logic signed [mdaa_pkg::IDX_W-1:0]    i_upper_bound,
    input  logic signed [mdaa_pkg::IDX_W-1:0]    i_index_value,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [mdaa_pkg::OUT_W-1:0]    o_address,
    output logic [mdaa_pkg::ID_W-1:0]            o_result_array
);
    import mdaa_pkg::*;

    // Descriptor storage
    logic [ADDR_W-1:0] base_mem   [MAX_ARRAYS];
    logic [SIZE_W-1:0] size_mem   [MAX_ARRAYS];
    logic [DIM_W-1:0]  count_mem  [MAX_ARRAYS];
    logic [IDX_W-1:0]  lower_mem  [NUM_SLOTS];
    logic [EXT_W-1:0]  extent_mem [NUM_SLOTS];

    t_state              r_state, n_state;
    logic [OUT_W-1:0]    r_acc;
    logic [OUT_W-1:0]    r_sum;
    logic [DIM_W-1:0]    r_comp_cnt;
    logic [DIM_W-1:0]    r_dim;
    logic [ID_W-1:0]     r_id;
    logic [IDX_W-1:0]    r_index;
    logic [IDX_W-1:0]    r_lower;
    logic [EXT_W-1:0]    r_extent;
    logic [ADDR_W-1:0]   r_base;
    logic [SIZE_W-1:0]   r_size;
    logic [DIM_W-1:0]    r_count;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_address;
    logic [ID_W-1:0]     r_result_array;

    logic                in_acc;
    logic                out_acc;
    logic                id_ok;
    logic                dim_ok;
    logic [SLOT_W-1:0]   wr_slot;
    logic [SLOT_W-1:0]   rd_slot;
    logic [EXT_W-1:0]    bound_diff;
    logic [EXT_W:0]      ext_plus;
    logic [OUT_W-1:0]    ext_full;
    logic [EXT_W-1:0]    idx_diff;
    logic [OUT_W-1:0]    diff_full;
    logic [DIM_W:0]      cnt_eff;
    logic                last_comp;
    logic [HALF_W-1:0]   mul_a;
    logic [HALF_W-1:0]   mul_b;
    logic [OUT_W-1:0]    mul_p;
    logic                out_free;

    // Handshakes
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Address decode
    assign id_ok   = (int'(i_array_id) < MAX_ARRAYS);
    assign dim_ok  = (int'(i_dim_pos) < MAX_DIMS);
    assign wr_slot = SLOT_W'(int'(i_array_id) * MAX_DIMS + int'(i_dim_pos));
    assign rd_slot = SLOT_W'(int'(i_array_id) * MAX_DIMS + int'(r_comp_cnt));

    // Bounds write stores upper - lower as a 33-bit signed value
    assign bound_diff = {i_upper_bound[IDX_W-1], i_upper_bound}
                      - {i_lower_bound[IDX_W-1], i_lower_bound};

    // Extent and index offset, sign extended to the accumulator width
    assign ext_plus  = {r_extent[EXT_W-1], r_extent} + (EXT_W+1)'(1);
    assign ext_full  = {{(OUT_W-EXT_W-1){ext_plus[EXT_W]}}, ext_plus};
    assign idx_diff  = {r_index[IDX_W-1], r_index} - {r_lower[IDX_W-1], r_lower};
    assign diff_full = {{(OUT_W-EXT_W){idx_diff[EXT_W-1]}}, idx_diff};

    // Effective dimension count and end-of-query test
    always_comb begin
        if (r_count == '0) begin
            cnt_eff = (DIM_W+1)'(1);
        end else if (int'(r_count) > MAX_DIMS) begin
            cnt_eff = (DIM_W+1)'(MAX_DIMS);
        end else begin
            cnt_eff = {1'b0, r_count};
        end
    end
    assign last_comp = (({1'b0, r_dim} + (DIM_W+1)'(1)) >= cnt_eff);

    // Shared multiplier operand select
    always_comb begin
        mul_a = r_acc[HALF_W-1:0];
        mul_b = ext_full[HALF_W-1:0];
        case (r_state)
            S_MUL_HL: begin
                mul_a = r_acc[OUT_W-1:HALF_W];
            end
            S_MUL_LH: begin
                mul_b = ext_full[OUT_W-1:HALF_W];
            end
            S_SCL_L: begin
                mul_b = HALF_W'(r_size);
            end
            S_SCL_H: begin
                mul_a = r_acc[OUT_W-1:HALF_W];
                mul_b = HALF_W'(r_size);
            end
            default: begin
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Descriptor writes
    always_ff @(posedge i_clk) begin
        if (in_acc && id_ok && (i_func == F_HEADER)) begin
            base_mem[i_array_id]  <= i_base_address;
            size_mem[i_array_id]  <= i_element_bytes;
            count_mem[i_array_id] <= i_dim_count;
        end
        if (in_acc && id_ok && dim_ok && (i_func == F_BOUNDS)) begin
            lower_mem[wr_slot]  <= i_lower_bound;
            extent_mem[wr_slot] <= bound_diff;
        end
    end

    // Descriptor reads, registered at the accept of an index component
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_func == F_INDEX)) begin
            r_base   <= base_mem[i_array_id];
            r_size   <= size_mem[i_array_id];
            r_count  <= count_mem[i_array_id];
            r_lower  <= lower_mem[rd_slot];
            r_extent <= extent_mem[rd_slot];
            r_index  <= i_index_value;
            r_id     <= i_array_id;
            r_dim    <= r_comp_cnt;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && id_ok && (i_func == F_INDEX)) begin
                    n_state = S_MUL_LL;
                end
            end
            S_MUL_LL: n_state = S_MUL_HL;
            S_MUL_HL: n_state = S_MUL_LH;
            S_MUL_LH: n_state = S_ADD;
            S_ADD: begin
                n_state = last_comp ? S_SCL_L : S_IDLE;
            end
            S_SCL_L:  n_state = S_SCL_H;
            S_SCL_H:  n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Accumulator, partial sums and component counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_comp_cnt <= '0;
            r_sum      <= '0;
        end else begin
            case (r_state)
                S_MUL_LL, S_SCL_L: begin
                    r_sum <= mul_p;
                end
                S_MUL_HL, S_MUL_LH, S_SCL_H: begin
                    r_sum[OUT_W-1:HALF_W] <= r_sum[OUT_W-1:HALF_W]
                                           + mul_p[HALF_W-1:0];
                end
                S_ADD: begin
                    r_acc <= r_sum + diff_full;
                    if (!last_comp) begin
                        r_comp_cnt <= r_dim + DIM_W'(1);
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_acc      <= '0;
                        r_comp_cnt <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_address      <= r_sum + OUT_W'(r_base);
            r_result_array <= r_id;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_address      = r_address;
    assign o_result_array = r_result_array;

endmodule
